/* rtl/core/bis_pkg.sv */
// Shared types and constants of the bilinear image scaler.
// Depends on nothing; every other file of the block but bis_ram uses it.
`default_nettype none

package bis_pkg;

   localparam int CHAN_W    = 8;
   localparam int PIX_W     = 3 * CHAN_W;
   localparam int COORD_W   = 11;
   localparam int SRC_DIM_W = 9;
   localparam int DST_DIM_W = 12;
   localparam int STEP_W    = 24;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam int MAX_SRC_WIDTH_DEF  = 256;
   localparam int MAX_SRC_HEIGHT_DEF = 256;
   localparam int FRAC_BITS_DEF      = 16;

   localparam logic [SRC_DIM_W-1:0] SRC_DIM_RESET = 9'd256;
   localparam logic [DST_DIM_W-1:0] DST_DIM_RESET = 12'd256;
   localparam logic [STEP_W-1:0]    STEP_RESET    = 24'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_DST_WIDTH  = 3'd2,
      CSR_DST_HEIGHT = 3'd3,
      CSR_STEP_X     = 3'd4,
      CSR_STEP_Y     = 3'd5
   } csr_index_type;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [COORD_W-1:0] x_coord;
      logic [COORD_W-1:0] y_coord;
      logic [CHAN_W-1:0]  in_chan0;
      logic [CHAN_W-1:0]  in_chan1;
      logic [CHAN_W-1:0]  in_chan2;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_chan0;
      logic [CHAN_W-1:0] out_chan1;
      logic [CHAN_W-1:0] out_chan2;
      logic              range_error;
   } rsp_type;

   // Sideband of one item on its way past the pixel store.
   typedef struct packed {
      logic valid;   // item expects a result
      logic err;     // coordinate outside destination
      logic r0p;     // parity of upper row
      logic r1p;     // parity of lower row
      logic c0p;     // parity of left column
      logic c1p;     // parity of right column
   } sel_type;

endpackage

`default_nettype wire

/* rtl/core/bilinear_image_scaler_unit.sv */
// Top level of the bilinear image scaler: handshakes, control registers, pipeline.
// Depends on bis_pkg, bis_coord_map, bis_pixel_store and bis_blend.
//
// Use: the req channel carries two kinds of transfer. mode 0 stores one source
// pixel at (x_coord, y_coord); a write outside the programmed source size is
// dropped and no write ever produces a response. mode 1 asks for destination
// pixel (x_coord, y_coord) and produces exactly one rsp transfer with the three
// interpolated channels, or zeros with range_error set when the coordinate is
// outside the destination size. Responses leave in request order.
//
// Throughput is one transfer per clock in either mode while rsp does not stall.
// A response passes the input register, coordinate stage, pixel store read,
// horizontal blend and output register. A pixel write is visible to any
// request taken on the following cycle or later.
//
// The source image sits in four RAM banks, each with one write and one read
// port, split by row and column parity, so the four neighbors of a request are
// fetched together.
//
// Reset is synchronous and empties the pipeline and restores the register
// defaults; the pixel store is not cleared and holds garbage until written.
// When rsp is stalled with a response waiting, the whole pipeline holds; one
// more request is still taken into the empty input register, after which req is
// stalled too. Write registers via csr_ only while idle; the block does not check.
`default_nettype none

module bilinear_image_scaler_unit #(
   parameter int MAX_SRC_WIDTH  = bis_pkg::MAX_SRC_WIDTH_DEF,
   parameter int MAX_SRC_HEIGHT = bis_pkg::MAX_SRC_HEIGHT_DEF,
   parameter int FRAC_BITS      = bis_pkg::FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire bis_pkg::req_type                   req_item,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output bis_pkg::rsp_type                        rsp_item,
   input  wire logic                               csr_write,
   input  wire logic [bis_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [bis_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int COL_W = ($clog2(MAX_SRC_WIDTH) < 2) ? 2 : $clog2(MAX_SRC_WIDTH);
   localparam int ROW_W = ($clog2(MAX_SRC_HEIGHT) < 2) ? 2 : $clog2(MAX_SRC_HEIGHT);
   localparam int BA_W  = COL_W + ROW_W - 2;

   // Control registers.
   logic [bis_pkg::SRC_DIM_W-1:0] src_width_ff;
   logic [bis_pkg::SRC_DIM_W-1:0] src_height_ff;
   logic [bis_pkg::DST_DIM_W-1:0] dst_width_ff;
   logic [bis_pkg::DST_DIM_W-1:0] dst_height_ff;
   logic [bis_pkg::STEP_W-1:0]    step_x_ff;
   logic [bis_pkg::STEP_W-1:0]    step_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= bis_pkg::SRC_DIM_RESET;
         src_height_ff <= bis_pkg::SRC_DIM_RESET;
         dst_width_ff  <= bis_pkg::DST_DIM_RESET;
         dst_height_ff <= bis_pkg::DST_DIM_RESET;
         step_x_ff     <= bis_pkg::STEP_RESET;
         step_y_ff     <= bis_pkg::STEP_RESET;
      end else if (csr_write) begin
         unique case (bis_pkg::csr_index_type'(csr_index))
            bis_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_data[bis_pkg::SRC_DIM_W-1:0];
            bis_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_data[bis_pkg::SRC_DIM_W-1:0];
            bis_pkg::CSR_DST_WIDTH:  dst_width_ff  <= csr_data[bis_pkg::DST_DIM_W-1:0];
            bis_pkg::CSR_DST_HEIGHT: dst_height_ff <= csr_data[bis_pkg::DST_DIM_W-1:0];
            bis_pkg::CSR_STEP_X:     step_x_ff     <= csr_data[bis_pkg::STEP_W-1:0];
            bis_pkg::CSR_STEP_Y:     step_y_ff     <= csr_data[bis_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   logic             a_valid_ff;
   logic             a_valid_in;
   bis_pkg::req_type a_item_ff;

   // The pipeline moves as one unless a finished response is held up.
   logic advance;
   logic req_accept;
   assign advance    = !(rsp_valid && rsp_stall);
   assign req_stall  = a_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         a_valid_in = 1'b1;
      end else if (advance) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      if (req_accept) begin
         a_item_ff <= req_item;
      end
   end

   logic                           wr_en;
   logic [1:0]                     wr_bank;
   logic [BA_W-1:0]                wr_addr;
   logic [bis_pkg::PIX_W-1:0]      wr_data;
   logic [3:0][BA_W-1:0]           rd_addr;
   bis_pkg::sel_type               map_sel;
   logic [FRAC_BITS-1:0]           map_fu;
   logic [FRAC_BITS-1:0]           map_fv;

   bis_coord_map #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
      .FRAC_BITS      (FRAC_BITS)
   ) u_coord_map (
      .clock      (clock),
      .reset      (reset),
      .enable     (advance),
      .in_valid   (a_valid_ff),
      .in_item    (a_item_ff),
      .src_width  (src_width_ff),
      .src_height (src_height_ff),
      .dst_width  (dst_width_ff),
      .dst_height (dst_height_ff),
      .step_x     (step_x_ff),
      .step_y     (step_y_ff),
      .wr_en      (wr_en),
      .wr_bank    (wr_bank),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .sel        (map_sel),
      .frac_u     (map_fu),
      .frac_v     (map_fv)
   );

   bis_pkg::sel_type               st_sel;
   logic [FRAC_BITS-1:0]           st_fu;
   logic [FRAC_BITS-1:0]           st_fv;
   logic [3:0][bis_pkg::PIX_W-1:0] st_pix;

   bis_pixel_store #(
      .BA_W      (BA_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_pixel_store (
      .clock      (clock),
      .reset      (reset),
      .enable     (advance),
      .wr_en      (wr_en),
      .wr_bank    (wr_bank),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .sel_in     (map_sel),
      .frac_u_in  (map_fu),
      .frac_v_in  (map_fv),
      .sel_out    (st_sel),
      .frac_u_out (st_fu),
      .frac_v_out (st_fv),
      .pix_out    (st_pix)
   );

   bis_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .sel       (st_sel),
      .frac_u    (st_fu),
      .frac_v    (st_fv),
      .pix       (st_pix),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Input is only held off when the input register is full and stuck.
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> a_valid_ff)
      else $error("req stalled with an empty input register");

   // The pixel store is never written while the pipeline is frozen.
   a_no_write_frozen: assert property (@(posedge clock) disable iff (reset)
      !advance |-> !wr_en)
      else $error("pixel write while the pipeline holds");

   // An out-of-range response carries a black pixel.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.range_error) |->
         (rsp_item.out_chan0 == '0 && rsp_item.out_chan1 == '0 &&
          rsp_item.out_chan2 == '0))
      else $error("range error with nonzero pixel");

   // A transfer stuck at the input is still there on the next cycle.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !advance) |=> (a_valid_ff && $stable(a_item_ff)))
      else $error("input register lost an item while stalled");

endmodule

`default_nettype wire

/* rtl/core/bis_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module bis_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/bis_coord_map.sv */
// Maps a transfer to source coordinates: step multiply, clamping and bank addressing.
// Depends on bis_pkg.
`default_nettype none

module bis_coord_map #(
   parameter int MAX_SRC_WIDTH  = bis_pkg::MAX_SRC_WIDTH_DEF,
   parameter int MAX_SRC_HEIGHT = bis_pkg::MAX_SRC_HEIGHT_DEF,
   parameter int FRAC_BITS      = bis_pkg::FRAC_BITS_DEF,
   localparam int COL_W = ($clog2(MAX_SRC_WIDTH) < 2) ? 2 : $clog2(MAX_SRC_WIDTH),
   localparam int ROW_W = ($clog2(MAX_SRC_HEIGHT) < 2) ? 2 : $clog2(MAX_SRC_HEIGHT),
   localparam int BA_W  = COL_W + ROW_W - 2
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              enable,
   input  wire logic                              in_valid,
   input  wire bis_pkg::req_type                  in_item,
   input  wire logic [bis_pkg::SRC_DIM_W-1:0]     src_width,
   input  wire logic [bis_pkg::SRC_DIM_W-1:0]     src_height,
   input  wire logic [bis_pkg::DST_DIM_W-1:0]     dst_width,
   input  wire logic [bis_pkg::DST_DIM_W-1:0]     dst_height,
   input  wire logic [bis_pkg::STEP_W-1:0]        step_x,
   input  wire logic [bis_pkg::STEP_W-1:0]        step_y,
   output logic                                   wr_en,
   output logic [1:0]                             wr_bank,
   output logic [BA_W-1:0]                        wr_addr,
   output logic [bis_pkg::PIX_W-1:0]              wr_data,
   output logic [3:0][BA_W-1:0]                   rd_addr,
   output bis_pkg::sel_type                       sel,
   output logic [FRAC_BITS-1:0]                   frac_u,
   output logic [FRAC_BITS-1:0]                   frac_v
);

   localparam int PROD_W = bis_pkg::COORD_W + bis_pkg::STEP_W;
   localparam int IU_W   = PROD_W - FRAC_BITS;

   // Front half: range check, last column/row fold and the two multiplies.
   logic                         x_err;
   logic                         y_err;
   logic [bis_pkg::COORD_W-1:0]  x_adj;
   logic [bis_pkg::COORD_W-1:0]  y_adj;
   logic [PROD_W-1:0]            u_in;
   logic [PROD_W-1:0]            v_in;

   always_comb begin
      x_err = {1'b0, in_item.x_coord} >= dst_width;
      y_err = {1'b0, in_item.y_coord} >= dst_height;
      x_adj = in_item.x_coord;
      y_adj = in_item.y_coord;
      if ((in_item.x_coord != '0) &&
          (({1'b0, in_item.x_coord} + 12'd1) == dst_width)) begin
         x_adj = in_item.x_coord - 11'd1;
      end
      if ((in_item.y_coord != '0) &&
          (({1'b0, in_item.y_coord} + 12'd1) == dst_height)) begin
         y_adj = in_item.y_coord - 11'd1;
      end
      u_in = PROD_W'(x_adj) * PROD_W'(step_x);
      v_in = PROD_W'(y_adj) * PROD_W'(step_y);
   end

   logic                         b_valid_ff;
   logic                         b_mode_ff;
   logic                         b_err_ff;
   logic [PROD_W-1:0]            b_u_ff;
   logic [PROD_W-1:0]            b_v_ff;
   logic [bis_pkg::COORD_W-1:0]  b_x_ff;
   logic [bis_pkg::COORD_W-1:0]  b_y_ff;
   logic [bis_pkg::PIX_W-1:0]    b_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         b_valid_ff <= in_valid;
      end
      if (enable) begin
         b_mode_ff <= in_item.mode;
         b_err_ff  <= x_err || y_err;
         b_u_ff    <= u_in;
         b_v_ff    <= v_in;
         b_x_ff    <= in_item.x_coord;
         b_y_ff    <= in_item.y_coord;
         b_pix_ff  <= {in_item.in_chan2, in_item.in_chan1, in_item.in_chan0};
      end
   end

   // Back half: effective source size, neighbor clamp, bank read and write addresses.
   logic [COL_W:0]    sw_eff;
   logic [ROW_W:0]    sh_eff;
   logic [IU_W-1:0]   iu;
   logic [IU_W-1:0]   iv;
   logic [COL_W-1:0]  c0;
   logic [COL_W-1:0]  c1;
   logic [ROW_W-1:0]  r0;
   logic [ROW_W-1:0]  r1;
   logic [COL_W-1:0]  wcol;
   logic [ROW_W-1:0]  wrow;
   logic              w_inside;

   always_comb begin
      if (src_width == '0) begin
         sw_eff = (COL_W + 1)'(1);
      end else if (32'(src_width) > MAX_SRC_WIDTH) begin
         sw_eff = (COL_W + 1)'(MAX_SRC_WIDTH);
      end else begin
         sw_eff = (COL_W + 1)'(src_width);
      end
      if (src_height == '0) begin
         sh_eff = (ROW_W + 1)'(1);
      end else if (32'(src_height) > MAX_SRC_HEIGHT) begin
         sh_eff = (ROW_W + 1)'(MAX_SRC_HEIGHT);
      end else begin
         sh_eff = (ROW_W + 1)'(src_height);
      end

      iu = b_u_ff[PROD_W-1:FRAC_BITS];
      iv = b_v_ff[PROD_W-1:FRAC_BITS];
      c0 = (iu >= IU_W'(sw_eff)) ? COL_W'(sw_eff - 1'b1) : COL_W'(iu);
      c1 = ((IU_W + 1)'(iu) + 1'b1 >= (IU_W + 1)'(sw_eff)) ?
           COL_W'(sw_eff - 1'b1) : COL_W'(iu + 1'b1);
      r0 = (iv >= IU_W'(sh_eff)) ? ROW_W'(sh_eff - 1'b1) : ROW_W'(iv);
      r1 = ((IU_W + 1)'(iv) + 1'b1 >= (IU_W + 1)'(sh_eff)) ?
           ROW_W'(sh_eff - 1'b1) : ROW_W'(iv + 1'b1);

      // Pixels interleave over four banks by row and column parity, so the
      // four neighbors always sit in different banks unless clamped together.
      for (int p = 0; p < 4; p++) begin
         logic [COL_W-1:0] col;
         logic [ROW_W-1:0] row;
         col = (c0[0] == p[0]) ? c0 : c1;
         row = (r0[0] == p[1]) ? r0 : r1;
         rd_addr[p] = {row[ROW_W-1:1], col[COL_W-1:1]};
      end

      w_inside = (32'(b_x_ff) < 32'(sw_eff)) && (32'(b_y_ff) < 32'(sh_eff));
      wcol     = COL_W'(b_x_ff);
      wrow     = ROW_W'(b_y_ff);
      wr_en    = enable && b_valid_ff && (b_mode_ff == bis_pkg::MODE_WRITE) && w_inside;
      wr_bank  = {wrow[0], wcol[0]};
      wr_addr  = {wrow[ROW_W-1:1], wcol[COL_W-1:1]};
      wr_data  = b_pix_ff;

      sel.valid = b_valid_ff && (b_mode_ff == bis_pkg::MODE_READ);
      sel.err   = b_err_ff;
      sel.r0p   = r0[0];
      sel.r1p   = r1[0];
      sel.c0p   = c0[0];
      sel.c1p   = c1[0];
      frac_u    = b_u_ff[FRAC_BITS-1:0];
      frac_v    = b_v_ff[FRAC_BITS-1:0];
   end

endmodule

`default_nettype wire

/* rtl/core/bis_pixel_store.sv */
// Source pixel store: four parity banks read together, neighbor selection after.
// Depends on bis_pkg and bis_ram.
`default_nettype none

module bis_pixel_store #(
   parameter int BA_W      = 14,
   parameter int FRAC_BITS = bis_pkg::FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              enable,
   input  wire logic                              wr_en,
   input  wire logic [1:0]                        wr_bank,
   input  wire logic [BA_W-1:0]                   wr_addr,
   input  wire logic [bis_pkg::PIX_W-1:0]         wr_data,
   input  wire logic [3:0][BA_W-1:0]              rd_addr,
   input  wire bis_pkg::sel_type                  sel_in,
   input  wire logic [FRAC_BITS-1:0]              frac_u_in,
   input  wire logic [FRAC_BITS-1:0]              frac_v_in,
   output bis_pkg::sel_type                       sel_out,
   output logic [FRAC_BITS-1:0]                   frac_u_out,
   output logic [FRAC_BITS-1:0]                   frac_v_out,
   output logic [3:0][bis_pkg::PIX_W-1:0]         pix_out
);

   logic [3:0][bis_pkg::PIX_W-1:0] bank_data;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      bis_ram #(
         .WIDTH (bis_pkg::PIX_W),
         .DEPTH (2 ** BA_W)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en && (wr_bank == 2'(b))),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (enable),
         .rd_addr (rd_addr[b]),
         .rd_data (bank_data[b])
      );
   end

   bis_pkg::sel_type     sel_ff;
   logic [FRAC_BITS-1:0] frac_u_ff;
   logic [FRAC_BITS-1:0] frac_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff.valid <= 1'b0;
      end else if (enable) begin
         sel_ff.valid <= sel_in.valid;
      end
      if (enable) begin
         sel_ff.err <= sel_in.err;
         sel_ff.r0p <= sel_in.r0p;
         sel_ff.r1p <= sel_in.r1p;
         sel_ff.c0p <= sel_in.c0p;
         sel_ff.c1p <= sel_in.c1p;
         frac_u_ff  <= frac_u_in;
         frac_v_ff  <= frac_v_in;
      end
   end

   // Order: upper left, upper right, lower left, lower right.
   always_comb begin
      pix_out[0] = bank_data[{sel_ff.r0p, sel_ff.c0p}];
      pix_out[1] = bank_data[{sel_ff.r0p, sel_ff.c1p}];
      pix_out[2] = bank_data[{sel_ff.r1p, sel_ff.c0p}];
      pix_out[3] = bank_data[{sel_ff.r1p, sel_ff.c1p}];
   end

   assign sel_out    = sel_ff;
   assign frac_u_out = frac_u_ff;
   assign frac_v_out = frac_v_ff;

endmodule

`default_nettype wire

/* rtl/core/bis_blend.sv */
// Two-stage bilinear blend: horizontal products, then vertical, into the output register.
// Depends on bis_pkg.
`default_nettype none

module bis_blend #(
   parameter int FRAC_BITS = bis_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire bis_pkg::sel_type              sel,
   input  wire logic [FRAC_BITS-1:0]          frac_u,
   input  wire logic [FRAC_BITS-1:0]          frac_v,
   input  wire logic [3:0][bis_pkg::PIX_W-1:0] pix,
   output logic                               rsp_valid,
   output bis_pkg::rsp_type                   rsp_item
);

   localparam int CW    = bis_pkg::CHAN_W;
   localparam int HW    = CW + FRAC_BITS;         // one horizontal sum
   localparam int HPW   = HW + 1;                 // its product width
   localparam int MPW   = HW + FRAC_BITS + 1;     // vertical product width
   localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

   logic [FRAC_BITS:0]       wu;
   logic [2:0][HW-1:0]       top_in;
   logic [2:0][HW-1:0]       bot_in;

   always_comb begin
      wu = ONE_Q - {1'b0, frac_u};
      for (int c = 0; c < 3; c++) begin
         top_in[c] = HW'(HPW'(pix[0][c*CW +: CW]) * HPW'(wu) +
                         HPW'(pix[1][c*CW +: CW]) * HPW'(frac_u));
         bot_in[c] = HW'(HPW'(pix[2][c*CW +: CW]) * HPW'(wu) +
                         HPW'(pix[3][c*CW +: CW]) * HPW'(frac_u));
      end
   end

   logic                    d_valid_ff;
   logic                    d_err_ff;
   logic [2:0][HW-1:0]      d_top_ff;
   logic [2:0][HW-1:0]      d_bot_ff;
   logic [FRAC_BITS-1:0]    d_fv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (enable) begin
         d_valid_ff <= sel.valid;
      end
      if (enable) begin
         d_err_ff <= sel.err;
         d_top_ff <= top_in;
         d_bot_ff <= bot_in;
         d_fv_ff  <= frac_v;
      end
   end

   logic [FRAC_BITS:0]      wv;
   logic [MPW-1:0]          mix;
   logic [2:0][CW-1:0]      chan;
   bis_pkg::rsp_type        rsp_in;

   always_comb begin
      wv = ONE_Q - {1'b0, d_fv_ff};
      for (int c = 0; c < 3; c++) begin
         mix = MPW'(d_top_ff[c]) * MPW'(wv) + MPW'(d_bot_ff[c]) * MPW'(d_fv_ff);
         chan[c] = mix[2*FRAC_BITS +: CW];
      end
      if (d_err_ff) begin
         rsp_in.out_chan0 = '0;
         rsp_in.out_chan1 = '0;
         rsp_in.out_chan2 = '0;
      end else begin
         rsp_in.out_chan0 = chan[0];
         rsp_in.out_chan1 = chan[1];
         rsp_in.out_chan2 = chan[2];
      end
      rsp_in.range_error = d_err_ff;
   end

   logic             rsp_valid_ff;
   bis_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= d_valid_ff;
      end
      if (enable) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire
